// ===== rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 16;   // Q8.8 gains
  localparam int BASE_W     = 7;    // base speed register
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_W     = 16;   // Q0.16 reflectance
  localparam int INTEG_W    = 32;   // saturating integral
  localparam int Q_SHIFT    = 24;   // gain * error lands in Q.24
  localparam int DIV_BITS   = 2;    // quotient bits per divider cycle

  // Register reset values
  localparam int RST_PROP_GAIN  = 2560;
  localparam int RST_INTEG_GAIN = 0;
  localparam int RST_DERIV_GAIN = 0;
  localparam int RST_BASE_SPEED = 35;
  localparam int RST_ADC_FLOOR  = 210;
  localparam int RST_ADC_CEIL   = 2900;
  localparam int RST_BLACK_THR  = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_BASE_SPEED = 3'd3,
    REG_ADC_FLOOR  = 3'd4,
    REG_ADC_CEIL   = 3'd5,
    REG_BLACK_THR  = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,   // pick sensor, handle clamped and degenerate cases
    S_DIV,    // radix-4 restoring divide for the fraction
    S_WMUL,   // weight * fraction
    S_WACC,   // accumulate line error
    S_MULP,   // Kp * err
    S_MULI,   // Ki * err
    S_MULD,   // Kd * (err - prior)
    S_ADDI,
    S_ADDD,
    S_TRUNC,  // divide by 2^24 toward zero
    S_CLAMP,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/line_follow_pid_steering.sv =====
// Line follower PID steering. Each input beat carries one set of reflectance samples;
// each is clamped to the floor/ceiling calibration, scaled to a Q0.16 fraction, weighted
// (leftmost most negative) and summed into a line error that drives a PID step. The
// output beat carries the two motor duties, the clamped steer value and a mask of the
// sensors reading above the black threshold. Integral and prior error persist between
// beats. Work runs through one shared 16 x 22 signed multiplier and one accumulator under
// a small sequencer; the block takes one set at a time. Each sensor is prepared, then
// divided (2 quotient bits per divider cycle) when its sample lies strictly between
// floor and ceiling, then weighted and accumulated; the PID step and output follow.
// The finished result sits in an output register, so the next set is accepted while
// it waits. Configuration writes are taken at any time with cfg_ready_o high, and
// must only be issued while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_steering #(
  parameter int NUM_SENSORS = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int FULL_SCALE  = 100,
  localparam int IN_TDATA_W  = ((NUM_SENSORS * SAMPLE_BITS + 7) / 8) * 8,
  localparam int DUTY_W      = $clog2(FULL_SCALE + 1),
  localparam int STEER_W     = DUTY_W + 1,
  localparam int OUT_W       = 2 * DUTY_W + STEER_W + NUM_SENSORS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // sample_0 .. sample_N-1, SAMPLE_BITS each, from bit 0 up
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]            s_axis_tdata,
  // left_duty, right_duty, steer_value, black_mask, from bit 0 up
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [OUT_TDATA_W-1:0]                m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lfps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lfps_pkg::*;

  localparam int IDX_W   = $clog2(NUM_SENSORS);
  localparam int ERR_W   = $clog2(NUM_SENSORS * (NUM_SENSORS / 2) + 1) + FRAC_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PROD_W  = GAIN_W + DIFF_W;
  localparam int SUMI_W  = PROD_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RAW_W   = ACC_W - Q_SHIFT;
  localparam int DSTEP   = FRAC_W / DIV_BITS;
  localparam int DCNT_W  = $clog2(DSTEP);
  localparam int CMP_W   = (DUTY_W > BASE_W) ? DUTY_W : BASE_W;
  localparam int SUMD_W  = STEER_W + 1;

  // configuration registers
  logic signed [GAIN_W-1:0]      kp_q, ki_q, kd_q;
  logic [BASE_W-1:0]             base_q;
  logic [SAMPLE_BITS-1:0]        floor_q, ceil_q, thr_q;

  // sequencer and datapath
  state_e                        state_q, state_d;
  logic [SAMPLE_BITS-1:0]        samples_q [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]        mask_q;
  logic [IDX_W-1:0]              idx_q;
  logic [DCNT_W-1:0]             cnt_q;
  logic [SAMPLE_BITS-1:0]        dvs_q, rem_q;
  logic [FRAC_W-1:0]             frac_q;
  logic signed [ERR_W-1:0]       err_q, prior_q;
  logic signed [DIFF_W-1:0]      diff_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [INTEG_W-1:0]     integ_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [RAW_W-1:0]       raw_q;
  logic signed [STEER_W-1:0]     steer_q;

  // output register
  logic                          out_valid_q;
  logic [DUTY_W-1:0]             left_q, right_q;
  logic [STEER_W-1:0]            steer_out_q;
  logic [NUM_SENSORS-1:0]        mask_out_q;

  logic [SAMPLE_BITS-1:0]        in_smp [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]        in_mask;
  logic                          in_acc;
  logic [SAMPLE_BITS-1:0]        cur_smp;
  logic                          degen, go_div;
  logic [FRAC_W-1:0]             prep_frac;
  logic [SAMPLE_BITS:0]          t1, t2;
  logic [SAMPLE_BITS-1:0]        r1, r2;
  logic                          b1, b2;
  logic signed [GAIN_W-1:0]      wgt, mul_a;
  logic signed [DIFF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUMI_W-1:0]      isum;
  logic signed [INTEG_W-1:0]     isat;
  logic signed [RAW_W-1:0]       trunc_val;
  logic [DUTY_W-1:0]             base_sat, limit;
  logic signed [RAW_W-1:0]       lim_s;
  logic signed [SUMD_W-1:0]      left_s, right_s;
  logic                          out_load;

  // input unpack and black mask
  always_comb begin
    for (int n = 0; n < NUM_SENSORS; n++) begin
      in_smp[n]  = s_axis_tdata[n*SAMPLE_BITS +: SAMPLE_BITS];
      in_mask[n] = in_smp[n] > thr_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // sensor selection and clamp cases
  assign cur_smp = samples_q[idx_q];
  assign degen   = (ceil_q <= floor_q);
  assign go_div  = !degen && (cur_smp > floor_q) && (cur_smp < ceil_q);

  always_comb begin
    if (degen) begin
      prep_frac = (cur_smp >= floor_q) ? '1 : '0;
    end else if (cur_smp <= floor_q) begin
      prep_frac = '0;
    end else begin
      prep_frac = '1;
    end
  end

  // two restoring divide steps; remainder stays below the divisor
  always_comb begin
    t1 = {rem_q, 1'b0};
    b1 = (t1 >= {1'b0, dvs_q});
    r1 = b1 ? SAMPLE_BITS'(t1 - {1'b0, dvs_q}) : t1[SAMPLE_BITS-1:0];
    t2 = {r1, 1'b0};
    b2 = (t2 >= {1'b0, dvs_q});
    r2 = b2 ? SAMPLE_BITS'(t2 - {1'b0, dvs_q}) : t2[SAMPLE_BITS-1:0];
  end

  // weight runs from -(N/2) for sensor 0 upward
  assign wgt = GAIN_W'(idx_q) - GAIN_W'(NUM_SENSORS / 2);

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      S_MULP:  begin mul_a = kp_q; mul_b = DIFF_W'(err_q); end
      S_MULI:  begin mul_a = ki_q; mul_b = DIFF_W'(err_q); end
      S_MULD:  begin mul_a = kd_q; mul_b = diff_q;         end
      default: begin mul_a = wgt;  mul_b = $signed(DIFF_W'(frac_q)); end
    endcase
  end
  assign prod = mul_a * mul_b;

  // integral add with 32-bit saturation
  assign isum = SUMI_W'(integ_q) + SUMI_W'(prod_q);
  always_comb begin
    if (isum[SUMI_W-1:INTEG_W-1] != '0 && isum[SUMI_W-1:INTEG_W-1] != '1) begin
      isat = isum[SUMI_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      isat = isum[INTEG_W-1:0];
    end
  end

  // shift toward zero
  assign trunc_val = acc_q[ACC_W-1:Q_SHIFT]
                   + RAW_W'(acc_q[ACC_W-1] && (acc_q[Q_SHIFT-1:0] != '0));

  // steer limit
  always_comb begin
    if (CMP_W'(base_q) > CMP_W'(FULL_SCALE)) begin
      base_sat = DUTY_W'(FULL_SCALE);
    end else begin
      base_sat = DUTY_W'(base_q);
    end
    limit = DUTY_W'(FULL_SCALE) - base_sat;
    lim_s = $signed(RAW_W'(limit));
  end

  assign left_s   = $signed(SUMD_W'(base_sat)) + SUMD_W'(steer_q);
  assign right_s  = $signed(SUMD_W'(base_sat)) - SUMD_W'(steer_q);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) begin
        state_d = S_PREP;
      end
      S_PREP:  state_d = go_div ? S_DIV : S_WMUL;
      S_DIV:   if (cnt_q == DCNT_W'(DSTEP - 1)) begin
        state_d = S_WMUL;
      end
      S_WMUL:  state_d = S_WACC;
      S_WACC:  state_d = (idx_q == IDX_W'(NUM_SENSORS - 1)) ? S_MULP : S_PREP;
      S_MULP:  state_d = S_MULI;
      S_MULI:  state_d = S_MULD;
      S_MULD:  state_d = S_ADDI;
      S_ADDI:  state_d = S_ADDD;
      S_ADDD:  state_d = S_TRUNC;
      S_TRUNC: state_d = S_CLAMP;
      S_CLAMP: state_d = S_DONE;
      S_DONE:  if (out_load) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= GAIN_W'(RST_PROP_GAIN);
      ki_q    <= GAIN_W'(RST_INTEG_GAIN);
      kd_q    <= GAIN_W'(RST_DERIV_GAIN);
      base_q  <= BASE_W'(RST_BASE_SPEED);
      floor_q <= SAMPLE_BITS'(RST_ADC_FLOOR);
      ceil_q  <= SAMPLE_BITS'(RST_ADC_CEIL);
      thr_q   <= SAMPLE_BITS'(RST_BLACK_THR);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PROP_GAIN:  kp_q    <= cfg_data_i;
        REG_INTEG_GAIN: ki_q    <= cfg_data_i;
        REG_DERIV_GAIN: kd_q    <= cfg_data_i;
        REG_BASE_SPEED: base_q  <= cfg_data_i[BASE_W-1:0];
        REG_ADC_FLOOR:  floor_q <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_ADC_CEIL:   ceil_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_BLACK_THR:  thr_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // PID state and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prior_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          cnt_q <= '0;
        end
        S_DIV:  cnt_q <= cnt_q + 1'b1;
        S_WACC: idx_q <= idx_q + 1'b1;
        S_MULP: prior_q <= err_q;
        S_MULD: integ_q <= isat;
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        samples_q <= in_smp;
        mask_q    <= in_mask;
        err_q     <= '0;
        dvs_q     <= ceil_q - floor_q;
      end
      S_PREP: begin
        frac_q <= prep_frac;
        rem_q  <= cur_smp - floor_q;
      end
      S_DIV: begin
        rem_q  <= r2;
        frac_q <= {frac_q[FRAC_W-DIV_BITS-1:0], b1, b2};
      end
      S_WMUL: prod_q <= prod;
      S_WACC: err_q  <= err_q + prod_q[ERR_W-1:0];
      S_MULP: begin
        prod_q <= prod;
        diff_q <= DIFF_W'(err_q) - DIFF_W'(prior_q);
      end
      S_MULI: begin
        prod_q <= prod;
        acc_q  <= ACC_W'(prod_q);
      end
      S_MULD:  prod_q <= prod;
      S_ADDI:  acc_q  <= acc_q + ACC_W'(integ_q);
      S_ADDD:  acc_q  <= acc_q + ACC_W'(prod_q);
      S_TRUNC: raw_q  <= trunc_val;
      S_CLAMP: begin
        if (raw_q > lim_s) begin
          steer_q <= STEER_W'(lim_s);
        end else if (raw_q < -lim_s) begin
          steer_q <= STEER_W'(-lim_s);
        end else begin
          steer_q <= STEER_W'(raw_q);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q      <= left_s[SUMD_W-1] ? '0 : left_s[DUTY_W-1:0];
      right_q     <= right_s[SUMD_W-1] ? '0 : right_s[DUTY_W-1:0];
      steer_out_q <= steer_q;
      mask_out_q  <= mask_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({mask_out_q, steer_out_q, right_q, left_q});

  // checks
  a_steer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(steer_out_q) <= $signed(STEER_W'(FULL_SCALE)) &&
                     $signed(steer_out_q) >= -$signed(STEER_W'(FULL_SCALE))))
    else $error("steer value beyond full scale");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (left_q <= DUTY_W'(FULL_SCALE) && right_q <= DUTY_W'(FULL_SCALE)))
    else $error("motor duty beyond full scale");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside the final step");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
